[hdl/tvss_pkg.sv]
package tvss_pkg;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam int unsigned VENT_MAX_LEVEL = 5;
  localparam int unsigned TENTHS_PER_LEVEL = 10;

  localparam logic signed [11:0] HEAT_ON_BELOW_RST = 12'sd50;
  localparam logic signed [11:0] HEAT_OFF_ABOVE_RST = 12'sd100;
  localparam logic signed [11:0] VENT_START_ABOVE_RST = 12'sd200;
  localparam logic [15:0] PULSE_BASE_RST = 16'd1000;
  localparam logic [13:0] PULSE_PER_LEVEL_RST = 14'd200;
  localparam logic [15:0] SLEW_STEP_RST = 16'd5;
  localparam logic [15:0] PULSE_RST = 16'd1000;

  typedef enum logic [2:0] {
    REG_HEAT_ON_BELOW    = 3'd0,
    REG_HEAT_OFF_ABOVE   = 3'd1,
    REG_VENT_START_ABOVE = 3'd2,
    REG_PULSE_BASE       = 3'd3,
    REG_PULSE_PER_LEVEL  = 3'd4,
    REG_SLEW_STEP        = 3'd5
  } reg_idx_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_TICK   = 1'b1
  } action_e;

  typedef struct packed {
    logic signed [11:0] heat_on_below;
    logic signed [11:0] heat_off_above;
    logic signed [11:0] vent_start_above;
    logic [15:0]        pulse_base;
    logic [13:0]        pulse_per_level;
    logic [15:0]        slew_step;
  } cfg_t;

endpackage

[hdl/tvss_regs.sv]
module tvss_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tvss_pkg::PADDR_W-1:0]    paddr,
  input  logic [tvss_pkg::PDATA_W-1:0]    pwdata,
  output logic [tvss_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output tvss_pkg::cfg_t                  cfg_o
);

  tvss_pkg::cfg_t     cfg_q;
  tvss_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = tvss_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heat_on_below    <= tvss_pkg::HEAT_ON_BELOW_RST;
      cfg_q.heat_off_above   <= tvss_pkg::HEAT_OFF_ABOVE_RST;
      cfg_q.vent_start_above <= tvss_pkg::VENT_START_ABOVE_RST;
      cfg_q.pulse_base       <= tvss_pkg::PULSE_BASE_RST;
      cfg_q.pulse_per_level  <= tvss_pkg::PULSE_PER_LEVEL_RST;
      cfg_q.slew_step        <= tvss_pkg::SLEW_STEP_RST;
    end else if (wr_en) begin
      unique case (idx)
        tvss_pkg::REG_HEAT_ON_BELOW:    cfg_q.heat_on_below    <= pwdata[11:0];
        tvss_pkg::REG_HEAT_OFF_ABOVE:   cfg_q.heat_off_above   <= pwdata[11:0];
        tvss_pkg::REG_VENT_START_ABOVE: cfg_q.vent_start_above <= pwdata[11:0];
        tvss_pkg::REG_PULSE_BASE:       cfg_q.pulse_base       <= pwdata[15:0];
        tvss_pkg::REG_PULSE_PER_LEVEL:  cfg_q.pulse_per_level  <= pwdata[13:0];
        tvss_pkg::REG_SLEW_STEP:        cfg_q.slew_step        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tvss_pkg::REG_HEAT_ON_BELOW:    prdata = {20'd0, cfg_q.heat_on_below};
      tvss_pkg::REG_HEAT_OFF_ABOVE:   prdata = {20'd0, cfg_q.heat_off_above};
      tvss_pkg::REG_VENT_START_ABOVE: prdata = {20'd0, cfg_q.vent_start_above};
      tvss_pkg::REG_PULSE_BASE:       prdata = {16'd0, cfg_q.pulse_base};
      tvss_pkg::REG_PULSE_PER_LEVEL:  prdata = {18'd0, cfg_q.pulse_per_level};
      tvss_pkg::REG_SLEW_STEP:        prdata = {16'd0, cfg_q.slew_step};
      default:                        prdata = '0;
    endcase
  end

endmodule

[hdl/thermostat_vent_servo_slew.sv]
// Heater hysteresis, vent level and slew-limited servo pulse controller.
// The input channel (in_valid_i, in_stall_o) carries one transaction per item:
// action_i selects a temperature sample or a servo tick, and temperature_x10_i
// holds the sample in signed tenths of a degree.
// The output channel (out_valid_o, out_stall_i) returns one transaction per
// item with the heater flag, vent level, target pulse and actual pulse as they
// stand after that item.
// An accepted item lands in an input register, is processed against the
// controller state once the output register is free, and its result sits in
// the output register; one item is accepted every cycle unless stalled.
// When the receiver stalls, the result holds in the output register and the
// item behind it holds in the input register; in_stall_o rises only when both
// are occupied.
// The APB port writes and reads the six setting registers at byte addresses
// 0, 4, ..., 20 and must only be written while no transaction is in flight.
// Reset empties both registers, turns the heater off, sets the vent level to
// zero, sets both pulse widths to 1000 and loads the default settings.
module thermostat_vent_servo_slew (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tvss_pkg::PADDR_W-1:0]   paddr,
  input  logic [tvss_pkg::PDATA_W-1:0]   pwdata,
  output logic [tvss_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic signed [15:0]             temperature_x10_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           heater_on_o,
  output logic [2:0]                     vent_level_o,
  output logic [15:0]                    target_pulse_o,
  output logic [15:0]                    actual_pulse_o
);

  tvss_pkg::cfg_t cfg;

  tvss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic                in_valid_q;
  tvss_pkg::action_e   in_action_q;
  logic signed [15:0]  in_temp_q;

  logic                heating_q, heating_d;
  logic [2:0]          level_q, level_d;
  logic [15:0]         target_q, target_d;
  logic [15:0]         drive_q, drive_d;

  logic                out_valid_q;
  logic                out_heater_q;
  logic [2:0]          out_level_q;
  logic [15:0]         out_target_q;
  logic [15:0]         out_actual_q;

  logic                advance;
  logic                fire;

  logic signed [15:0]  on_thr;
  logic signed [15:0]  off_thr;
  logic signed [16:0]  diff;
  logic [2:0]          level_new;
  logic [16:0]         prod;
  logic [17:0]         sum;
  logic [15:0]         target_new;
  logic [16:0]         up_sum;
  logic [15:0]         gap;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_action_q <= tvss_pkg::action_e'(action_i);
      in_temp_q   <= temperature_x10_i;
    end
  end

  always_comb begin
    on_thr  = 16'(cfg.heat_on_below);
    off_thr = 16'(cfg.heat_off_above);
    diff    = 17'(in_temp_q) - 17'(cfg.vent_start_above);

    level_new = '0;
    for (int unsigned k = 1; k <= tvss_pkg::VENT_MAX_LEVEL; k++) begin
      if (diff >= $signed(17'(k * tvss_pkg::TENTHS_PER_LEVEL))) begin
        level_new = 3'(k);
      end
    end

    prod       = {14'd0, level_new} * {3'd0, cfg.pulse_per_level};
    sum        = {2'd0, cfg.pulse_base} + {1'b0, prod};
    target_new = (sum[17:16] != 2'd0) ? 16'hFFFF : sum[15:0];

    up_sum = {1'b0, drive_q} + {1'b0, cfg.slew_step};
    gap    = drive_q - target_q;

    heating_d = heating_q;
    level_d   = level_q;
    target_d  = target_q;
    drive_d   = drive_q;

    case (in_action_q)
      tvss_pkg::ACT_SAMPLE: begin
        if (in_temp_q < on_thr && !heating_q) begin
          heating_d = 1'b1;
        end else if (in_temp_q > off_thr && heating_q) begin
          heating_d = 1'b0;
        end
        if (!heating_d) begin
          level_d  = level_new;
          target_d = target_new;
        end
      end
      default: begin
        if (drive_q < target_q) begin
          drive_d = (up_sum > {1'b0, target_q}) ? target_q : up_sum[15:0];
        end else if (drive_q > target_q) begin
          drive_d = (cfg.slew_step >= gap) ? target_q : drive_q - cfg.slew_step;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heating_q <= 1'b0;
      level_q   <= '0;
      target_q  <= tvss_pkg::PULSE_RST;
      drive_q   <= tvss_pkg::PULSE_RST;
    end else if (fire) begin
      heating_q <= heating_d;
      level_q   <= level_d;
      target_q  <= target_d;
      drive_q   <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_heater_q <= heating_d;
      out_level_q  <= level_d;
      out_target_q <= target_d;
      out_actual_q <= drive_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign heater_on_o    = out_heater_q;
  assign vent_level_o   = out_level_q;
  assign target_pulse_o = out_target_q;
  assign actual_pulse_o = out_actual_q;

`ifndef SYNTH
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= 3'(tvss_pkg::VENT_MAX_LEVEL))
    else $error("Vent level exceeds its maximum.");

  a_heat_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(heating_q) |-> $past(fire && in_action_q == tvss_pkg::ACT_SAMPLE))
    else $error("Heater turned on without a sample transaction.");

  a_drive_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(drive_q) |-> $past(fire && in_action_q == tvss_pkg::ACT_TICK))
    else $error("Actual pulse changed without a tick transaction.");

  a_target_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(target_q) |-> $past(fire && in_action_q == tvss_pkg::ACT_SAMPLE))
    else $error("Target pulse changed without a sample transaction.");
`endif

endmodule
